@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the Polish expression perturber.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/pep_pkg.sv @@
// Package for the Polish expression perturber: item structs, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package pep_pkg;
   localparam int MAX_LENGTH_DEF  = 64;
   localparam int RANDOM_BITS_DEF = 16;
   localparam int ELEM_W = 7;
   localparam int POS_W  = 6;
   localparam int RAND_W = 16;
   localparam int LEN_W  = 7;

   typedef enum logic [2:0] {
      CMD_WRITE     = 3'd0,
      CMD_SWAP_OPND = 3'd1,
      CMD_COMPL     = 3'd2,
      CMD_SWAP_ADJ  = 3'd3,
      CMD_READ      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_NONE   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RDWAIT,
      S_SCAN1,
      S_PICK,
      S_SCAN2,
      S_DECIDE,
      S_CH_RD,
      S_CH_WR
   } state_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [POS_W-1:0]  position;
      logic [ELEM_W-1:0] element_value;
      logic [RAND_W-1:0] random_first;
      logic [RAND_W-1:0] random_second;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [POS_W-1:0]  first_pos;
      logic [POS_W-1:0]  second_pos;
      logic [ELEM_W-1:0] read_value;
   } rsp_type;
endpackage

@@ rtl/pep_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ rtl/polish_expression_perturber.sv @@
// Top level of the Polish expression perturber: command FSM and scan logic.
// Depends on pep_pkg, pep_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input: present a command item on req_item and raise start; the item is
//   taken at an edge where start is high and busy is low. busy stays high
//   while the item is worked on.
//   Result: one result item per command, shown on rsp_item for exactly one
//   cycle with rsp_valid high. The receiver cannot stall; take it or lose it.
//   Configuration: csr_we/csr_wdata write the expression length; write only
//   while busy is low.
//   Steps after acceptance: write and unused commands answer from idle;
//   read waits for the registered memory read data;
//     swap operands / swap adjacent: two passes over the expression
//     memory, one entry per cycle through its single read port, plus a
//     step each for the pick multiply and the decision; only the counting
//     pass runs when no position is eligible;
//     complement chain: the passes, pick and decision, then one read and
//     one write-back per flipped operator; the run ends at an operand or
//     at the end of the expression.
//   Reset: clears the FSM and sets the length to 1. The expression memory is
//   not cleared; entries are undefined until written.
module polish_expression_perturber
   import pep_pkg::*;
#(
   parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_valid,
   output rsp_type           rsp_item,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata
);
   localparam int AW = $clog2(MAX_LENGTH);
   localparam int LW = $clog2(MAX_LENGTH + 1);
   localparam int RW = (RANDOM_BITS < RAND_W) ? RANDOM_BITS : RAND_W;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  csr_len_ff;
   logic [2:0]        cmd_ff, cmd_in;
   logic [RAND_W-1:0] rnd1_ff, rnd1_in, rnd2_ff, rnd2_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [LW-1:0]     rd_idx_ff, rd_idx_in;
   logic              dv_ff, dv_in;
   logic [AW-1:0]     di_ff, di_in;
   logic [LW-1:0]     cnt_ff, cnt_in, opc_ff, opc_in;
   logic [LW-1:0]     pa_ff, pa_in, pb_ff, pb_in;
   logic [AW-1:0]     fa_ff, fa_in, fb_ff, fb_in;
   logic              found_ff, found_in;
   logic [ELEM_W-1:0] prev_ff, prev_in, prev2_ff, prev2_in;
   logic [ELEM_W-1:0] vi_ff, vi_in, vi1_ff, vi1_in, vim1_ff, vim1_in, vi2_ff, vi2_in;
   logic              ballot_ff, ballot_in;
   logic [LW-1:0]     walk_ff, walk_in;
   logic [AW-1:0]     p2_ff, p2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   logic [ELEM_W-1:0] mem_wr_data, mem_rd_data;

   logic [LW-1:0]     eff_len;
   logic [RW+LW-1:0]  prod_a, prod_b;
   logic              cur_op, hit, pos_ok, scan_done, normal;
   logic [AW:0]       fa_next;

   pep_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LENGTH)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Effective length: clamp the register to the store depth.
   assign eff_len = (int'(csr_len_ff) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(csr_len_ff);
   assign pos_ok  = int'(req_item.position) < MAX_LENGTH;

   // Scale the random fractions by the eligible count.
   assign prod_a  = rnd1_ff[RW-1:0] * cnt_ff;
   assign prod_b  = rnd2_ff[RW-1:0] * cnt_ff;

   assign cur_op  = mem_rd_data[ELEM_W-1];
   assign fa_next = {1'b0, fa_ff} + 1'b1;
   assign scan_done = (rd_idx_ff == len_ff) && !dv_ff;

   // Hit for the current scan entry, by move kind.
   always_comb begin
      case (cmd_ff)
         CMD_SWAP_OPND: hit = !cur_op;
         CMD_COMPL:     hit = cur_op;
         CMD_SWAP_ADJ:  hit = (di_ff != '0) && (cur_op != prev_ff[ELEM_W-1]);
         default:       hit = 1'b0;
      endcase
   end

   // Normality for the chosen boundary pair.
   always_comb begin
      if (vi_ff[ELEM_W-1]) begin
         normal = (int'(fa_ff) + 2 < int'(len_ff)) &&
                  !(vi2_ff[ELEM_W-1] && (vi_ff[0] == vi2_ff[0]));
      end else begin
         normal = (fa_ff != '0) &&
                  !(vi1_ff[ELEM_W-1] && vim1_ff[ELEM_W-1] && (vi1_ff[0] == vim1_ff[0]));
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rnd1_in      = rnd1_ff;
      rnd2_in      = rnd2_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = 1'b0;
      di_in        = di_ff;
      cnt_in       = cnt_ff;
      opc_in       = opc_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      vi_in        = vi_ff;
      vi1_in       = vi1_ff;
      vim1_in      = vim1_ff;
      vi2_in       = vi2_ff;
      ballot_in    = ballot_ff;
      walk_in      = walk_ff;
      p2_in        = p2_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = AW'(req_item.position);
      mem_wr_data  = req_item.element_value;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = AW'(req_item.position);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_item.command;
               rnd1_in     = req_item.random_first;
               rnd2_in     = req_item.random_second;
               len_in      = eff_len;
               rd_idx_in   = '0;
               cnt_in      = '0;
               rsp_item_in = '0;
               case (req_item.command)
                  CMD_WRITE: begin
                     mem_wr_en    = pos_ok;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_READ: begin
                     if (pos_ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = S_RDWAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_SWAP_OPND, CMD_COMPL, CMD_SWAP_ADJ: begin
                     state_in = S_SCAN1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_RDWAIT: begin
            rsp_item_in.read_value = mem_rd_data;
            rsp_valid_in           = 1'b1;
            state_in               = S_IDLE;
         end

         S_SCAN1, S_SCAN2: begin
            // Issue the next read while entries remain.
            if (rd_idx_ff < len_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
               dv_in       = 1'b1;
               di_in       = rd_idx_ff[AW-1:0];
            end
            if (dv_ff) begin
               prev_in  = mem_rd_data;
               prev2_in = prev_ff;
               cnt_in   = cnt_ff + LW'(hit);
               opc_in   = opc_ff + LW'(cur_op);
               if (state_ff == S_SCAN2) begin
                  if (hit && (cnt_ff == pa_ff)) begin
                     found_in = 1'b1;
                     if (cmd_ff == CMD_SWAP_ADJ) begin
                        fa_in     = di_ff - 1'b1;
                        vi_in     = prev_ff;
                        vi1_in    = mem_rd_data;
                        vim1_in   = prev2_ff;
                        ballot_in = !cur_op ||
                                    ((2 * (int'(opc_ff) + 1)) < int'(di_ff));
                     end else begin
                        fa_in = di_ff;
                     end
                  end
                  if (hit && (cnt_ff == pb_ff)) begin
                     fb_in = di_ff;
                  end
                  if (found_ff && (int'(di_ff) == int'(fa_ff) + 2)) begin
                     vi2_in = mem_rd_data;
                  end
               end
            end
            if (scan_done) begin
               if (state_ff == S_SCAN1) begin
                  if ((cmd_ff == CMD_SWAP_OPND) ? (cnt_ff < LW'(2)) : (cnt_ff == '0)) begin
                     rsp_item_in.status = ST_NONE;
                     rsp_valid_in       = 1'b1;
                     state_in           = S_IDLE;
                  end else begin
                     state_in = S_PICK;
                  end
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_PICK: begin
            pa_in     = LW'(prod_a >> RANDOM_BITS);
            pb_in     = LW'(prod_b >> RANDOM_BITS);
            rd_idx_in = '0;
            cnt_in    = '0;
            opc_in    = '0;
            found_in  = 1'b0;
            state_in  = S_SCAN2;
         end

         S_DECIDE: begin
            rsp_item_in.first_pos = POS_W'(fa_ff);
            case (cmd_ff)
               CMD_SWAP_OPND: begin
                  rsp_item_in.second_pos = POS_W'(fb_ff);
                  rsp_item_in.status     = (pa_ff == pb_ff) ? ST_REJECT : ST_OK;
                  rsp_valid_in           = 1'b1;
                  state_in               = S_IDLE;
               end
               CMD_SWAP_ADJ: begin
                  rsp_item_in.second_pos = POS_W'(fa_next);
                  rsp_item_in.status     = (ballot_ff && normal) ? ST_OK : ST_REJECT;
                  rsp_valid_in           = 1'b1;
                  state_in               = S_IDLE;
               end
               default: begin
                  walk_in  = LW'(fa_ff);
                  state_in = S_CH_RD;
               end
            endcase
         end

         S_CH_RD: begin
            if (walk_ff < len_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = walk_ff[AW-1:0];
               state_in    = S_CH_WR;
            end else begin
               rsp_item_in.second_pos = POS_W'(p2_ff);
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end

         S_CH_WR: begin
            if (cur_op) begin
               // Flip the cut direction and write it back.
               mem_wr_en   = 1'b1;
               mem_wr_addr = walk_ff[AW-1:0];
               mem_wr_data = {1'b1, {(ELEM_W-2){1'b0}}, ~mem_rd_data[0]};
               p2_in       = walk_ff[AW-1:0];
               walk_in     = walk_ff + 1'b1;
               state_in    = S_CH_RD;
            end else begin
               rsp_item_in.second_pos = POS_W'(p2_ff);
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_len_ff   <= LEN_W'(1);
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rnd1_ff     <= rnd1_in;
      rnd2_ff     <= rnd2_in;
      len_ff      <= len_in;
      rd_idx_ff   <= rd_idx_in;
      di_ff       <= di_in;
      cnt_ff      <= cnt_in;
      opc_ff      <= opc_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      found_ff    <= found_in;
      prev_ff     <= prev_in;
      prev2_ff    <= prev2_in;
      vi_ff       <= vi_in;
      vi1_ff      <= vi1_in;
      vim1_ff     <= vim1_in;
      vi2_ff      <= vi2_in;
      ballot_ff   <= ballot_in;
      walk_ff     <= walk_in;
      p2_ff       <= p2_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // An accepted item either finishes at once or keeps the block busy.
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid,
                "accepted item neither busy nor answered")
   // A result leaves the block idle.
   `ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   // Scan data only arrives inside a scan pass.
   `ASSERT_IMPLIES(a_scan_data, clock, reset, dv_ff,
                   (state_ff == S_SCAN1) || (state_ff == S_SCAN2),
                   "scan data outside a pass")
   // Chain write-back always stores an operator.
   `ASSERT_IMPLIES(a_chain_wr, clock, reset, mem_wr_en && (state_ff == S_CH_WR),
                   mem_wr_data[ELEM_W-1], "chain wrote an operand")
endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for polish_expression_perturber: drives command items,
// predicts each result in-bench and checks every strobed result in order.
// Depends on pep_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
   import pep_pkg::*;

   localparam int          CYCLE_LIMIT  = 2000000;
   localparam int          STORE_DEPTH  = MAX_LENGTH_DEF;
   localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
   localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
   localparam logic [6:0]  OPERATOR_BIT = 7'h40;
   localparam logic [6:0]  HORIZ_BIT    = 7'h01;
   localparam int          SCAN_OPERAND  = 0;
   localparam int          SCAN_OPERATOR = 1;
   localparam int          SCAN_BOUNDARY = 2;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_item = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;

   // bench-side copy of the block: stored expression and length register
   logic [6:0]       expr_mirror [STORE_DEPTH];
   int               length_reg;

   req_type          pending_items[$];
   rsp_type          awaited_results[$];
   int               sender_idle_pct = 0;
   int               mismatches = 0;
   int               cycle_count = 0;

   polish_expression_perturber DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int live_length();
      return (length_reg > STORE_DEPTH) ? STORE_DEPTH : length_reg;
   endfunction

   function automatic bit is_operator(int i);
      return expr_mirror[i][6];
   endfunction

   // scale a random fraction onto [0, count)
   function automatic int scale_pick(logic [15:0] r, int count);
      longint unsigned prod;
      prod = longint'(r) * longint'(count);
      return int'(prod >> RANDOM_BITS_DEF);
   endfunction

   // find the k-th eligible position of a scan class, and count them all
   function automatic void find_eligible(input int mode, input int k,
                                         output int pos, output int count);
      int  n;
      int  L;
      bit  hit;
      n = 0;
      pos = 0;
      L = live_length();
      for (int i = 0; i < L; i++) begin
         if (mode == SCAN_OPERAND) hit = !is_operator(i);
         else if (mode == SCAN_OPERATOR) hit = is_operator(i);
         else hit = (i + 1 < L) && (is_operator(i) != is_operator(i + 1));
         if (hit) begin
            if (n == k) pos = i;
            n++;
         end
      end
      count = n;
   endfunction

   // work out the result of one accepted item and update the mirror
   function automatic rsp_type perturb_outcome(req_type it);
      rsp_type res;
      int      cnt, a, b, p, q, i, n, L;
      bit      ballot, normal;
      res = '0;
      res.status = ST_OK;
      L = live_length();
      case (it.command)
         CMD_WRITE: begin
            expr_mirror[it.position] = it.element_value;
         end
         CMD_READ: begin
            res.read_value = expr_mirror[it.position];
         end
         CMD_SWAP_OPND: begin
            find_eligible(SCAN_OPERAND, 0, p, cnt);
            if (cnt < 2) begin
               res.status = ST_NONE;
            end else begin
               a = scale_pick(it.random_first, cnt);
               b = scale_pick(it.random_second, cnt);
               find_eligible(SCAN_OPERAND, a, p, cnt);
               find_eligible(SCAN_OPERAND, b, q, cnt);
               res.first_pos  = p[5:0];
               res.second_pos = q[5:0];
               if (a == b) res.status = ST_REJECT;
            end
         end
         CMD_COMPL: begin
            find_eligible(SCAN_OPERATOR, 0, p, cnt);
            if (cnt == 0) begin
               res.status = ST_NONE;
            end else begin
               find_eligible(SCAN_OPERATOR, scale_pick(it.random_first, cnt), i, cnt);
               res.first_pos = i[5:0];
               // flip the run of operators up to the next operand or the end
               while (i < L && is_operator(i)) begin
                  expr_mirror[i] = OPERATOR_BIT | ((expr_mirror[i] & HORIZ_BIT) ^ HORIZ_BIT);
                  res.second_pos = i[5:0];
                  i++;
               end
            end
         end
         CMD_SWAP_ADJ: begin
            find_eligible(SCAN_BOUNDARY, 0, p, cnt);
            if (cnt == 0) begin
               res.status = ST_NONE;
            end else begin
               find_eligible(SCAN_BOUNDARY, scale_pick(it.random_first, cnt), i, cnt);
               res.first_pos  = i[5:0];
               res.second_pos = 6'(i + 1);
               ballot = 1'b1;
               if (is_operator(i + 1)) begin
                  n = 0;
                  for (int k = 0; k <= i + 1; k++) if (is_operator(k)) n++;
                  ballot = (2 * n) < (i + 1);
               end
               if (is_operator(i))
                  normal = (i + 2 < L) && !(is_operator(i + 2) &&
                           expr_mirror[i][0] == expr_mirror[i + 2][0]);
               else
                  normal = (i > 0) && !(is_operator(i + 1) && is_operator(i - 1) &&
                           expr_mirror[i + 1][0] == expr_mirror[i - 1][0]);
               if (!ballot || !normal) res.status = ST_REJECT;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver: present the next pending item, predicting each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) awaited_results.push_back(perturb_outcome(req_item));
         if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_item <= pending_items.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result must match the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h with nothing outstanding", rsp_item);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_item.status !== want.status || rsp_item.first_pos !== want.first_pos ||
                rsp_item.second_pos !== want.second_pos ||
                rsp_item.read_value !== want.read_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st=%0d p1=%0d p2=%0d rv=%h, got st=%0d p1=%0d p2=%0d rv=%h",
                           want.status, want.first_pos, want.second_pos, want.read_value,
                           rsp_item.status, rsp_item.first_pos, rsp_item.second_pos,
                           rsp_item.read_value);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic req_type build_item(logic [2:0] cmd, int pos, logic [6:0] val,
                                          logic [15:0] r1, logic [15:0] r2);
      req_type it;
      it.command       = cmd;
      it.position      = pos[5:0];
      it.element_value = val;
      it.random_first  = r1;
      it.random_second = r2;
      return it;
   endfunction

   function automatic logic [6:0] operand_of(int id);
      return 7'(id) & ~OPERATOR_BIT;
   endfunction

   function automatic logic [6:0] operator_of(bit horiz);
      return OPERATOR_BIT | (horiz ? HORIZ_BIT : 7'h00);
   endfunction

   // hold until every item is taken and every result has come back
   task automatic drain();
      while (pending_items.size() > 0 || start || busy || awaited_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_length(int v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= LEN_W'(v);
      length_reg = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // queue a well-formed skeleton over the live length: c c op c op ...
   task automatic queue_normalised();
      int L;
      L = live_length();
      for (int i = 0; i < L; i++) begin
         if (i == 0 || (i % 2) == 1)
            pending_items.push_back(build_item(CMD_WRITE, i,
               operand_of($urandom_range(63)), $urandom, $urandom));
         else
            pending_items.push_back(build_item(CMD_WRITE, i,
               operator_of((i / 2) % 2 == 1), $urandom, $urandom));
      end
   endtask

   task automatic queue_random_item();
      int sel;
      logic [2:0] cmd;
      sel = $urandom_range(99);
      if (sel < 20) cmd = CMD_WRITE;
      else if (sel < 32) cmd = CMD_READ;
      else if (sel < 50) cmd = CMD_SWAP_OPND;
      else if (sel < 72) cmd = CMD_COMPL;
      else if (sel < 95) cmd = CMD_SWAP_ADJ;
      else cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      // every entry is already written, so any position may be read
      pending_items.push_back(build_item(cmd, $urandom_range(63), 7'($urandom),
                                         16'($urandom), 16'($urandom)));
   endtask

   initial begin
      int lengths [6] = '{64, 127, 9, 2, 0, 33};
      int idles   [3] = '{37, 61, 0};
      length_reg = 1;
      for (int i = 0; i < STORE_DEPTH; i++) expr_mirror[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small expression "1 2 V 3 H"
      set_length(5);
      pending_items.push_back(build_item(CMD_WRITE, 0, operand_of(1), 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_WRITE, 1, operand_of(2), 16'hffff, 16'hffff));
      pending_items.push_back(build_item(CMD_WRITE, 2, operator_of(1'b0), 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_WRITE, 3, operand_of(3), 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_WRITE, 4, operator_of(1'b1), 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_WRITE, 63, 7'h7f, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_READ, 0, 7'h00, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_READ, 63, 7'h7f, 16'hffff, 16'hffff));
      pending_items.push_back(build_item(CMD_SWAP_OPND, 0, 7'h0, 16'h0, 16'hffff));
      pending_items.push_back(build_item(CMD_SWAP_OPND, 0, 7'h0, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_SWAP_ADJ, 0, 7'h0, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_SWAP_ADJ, 0, 7'h0, 16'h8000, 16'h0));
      pending_items.push_back(build_item(CMD_SWAP_ADJ, 0, 7'h0, 16'hffff, 16'h0));
      pending_items.push_back(build_item(CMD_COMPL, 0, 7'h0, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_COMPL, 0, 7'h0, 16'hffff, 16'h0));
      pending_items.push_back(build_item(CMD_READ, 4, 7'h0, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_SPARE_LO, 0, 7'h0, 16'h0, 16'h0));
      pending_items.push_back(build_item(CMD_SPARE_HI, 63, 7'h7f, 16'hffff, 16'hffff));
      drain();
      // an empty expression: every move finds nothing
      set_length(0);
      pending_items.push_back(build_item(CMD_SWAP_OPND, 0, 7'h0, 16'h1234, 16'h4321));
      pending_items.push_back(build_item(CMD_COMPL, 0, 7'h0, 16'h1234, 16'h0));
      pending_items.push_back(build_item(CMD_SWAP_ADJ, 0, 7'h0, 16'h1234, 16'h0));
      drain();

      // fill the whole store so that every later scan and read sees written data
      set_length(127);
      for (int i = 0; i < STORE_DEPTH; i++)
         pending_items.push_back(build_item(CMD_WRITE, i, 7'($urandom), 16'($urandom),
                                            16'($urandom)));
      drain();

      // random phases; each drain is also the sender's pause until all results are in
      for (int ph = 0; ph < 6; ph++) begin
         sender_idle_pct = idles[ph / 2];
         set_length(lengths[ph]);
         for (int n = 0; n < 55; n++) begin
            if ($urandom_range(99) < 1) queue_normalised();
            queue_random_item();
         end
         drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
